/* rtl/core/afu8_pkg.sv */
`timescale 1ns / 1ps

package afu8_pkg;

  // Sample encodings held in the format register
  typedef enum logic [1:0] {
    FmtPcm   = 2'd0,
    FmtFloat = 2'd1,
    FmtAlaw  = 2'd2,
    FmtUlaw  = 2'd3
  } fmt_e;

  // Register indexes on the APB port (byte address = 4 * index)
  typedef enum logic [1:0] {
    RegFormat   = 2'd0,
    RegBits     = 2'd1,
    RegChannels = 2'd2,
    RegStereo   = 2'd3
  } reg_e;

  localparam int unsigned ProdW = 84;  // 53-bit mantissa times (2^31 - 1)
  localparam int unsigned ShW   = 7;   // right shift of up to 83
  localparam logic [7:0]  Silence = 8'h80;

  // Control that travels beside the payload through the pipeline
  typedef struct packed {
    logic valid;
    logic final_frame;
  } ctl_t;

endpackage

/* rtl/core/audio_frame_to_u8_converter_top.sv */
`timescale 1ns / 1ps

// Audio frame to unsigned 8-bit converter. Pulse start with a frame on
// frame_low_i / frame_high_i (byte 0 in bits 7..0); busy never rises, so a
// new frame may be issued on every clock. Each frame yields exactly one beat
// on done_o after it has passed the conversion lanes (decode and scaling,
// then alignment and saturation) and the output register. done_o is high
// for a single cycle and there is no way to hold it off: capture left_sample_o,
// right_sample_o, right_present_o and final_out_o in that cycle. Two identical
// lanes convert the left and the right sample side by side; the output stage
// copies left to right for a mono file and parks right at 0x80 when stereo
// output is off. Program the four configuration registers over APB only while
// no beat is outstanding.
module audio_frame_to_u8_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic [63:0] frame_low_i,
  input  logic [63:0] frame_high_i,
  input  logic        final_frame_i,
  // Result channel
  output logic        done_o,
  output logic [7:0]  left_sample_o,
  output logic [7:0]  right_sample_o,
  output logic        right_present_o,
  output logic        final_out_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import afu8_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  fmt_e       fmt_d, fmt_q;
  logic [6:0] bits_d, bits_q;
  logic [1:0] chan_d, chan_q;
  logic       stereo_d, stereo_q;
  logic       apb_wr;
  reg_e       reg_sel;

  assign pready  = 1'b1;
  assign apb_wr  = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_comb begin
    fmt_d    = fmt_q;
    bits_d   = bits_q;
    chan_d   = chan_q;
    stereo_d = stereo_q;
    if (apb_wr) begin
      case (reg_sel)
        RegFormat:   fmt_d    = fmt_e'(pwdata[1:0]);
        RegBits:     bits_d   = pwdata[6:0];
        RegChannels: chan_d   = pwdata[1:0];
        RegStereo:   stereo_d = pwdata[0];
        default:     fmt_d    = fmt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FmtPcm;
      bits_q   <= 7'd8;
      chan_q   <= 2'd1;
      stereo_q <= 1'b0;
    end else begin
      fmt_q    <= fmt_d;
      bits_q   <= bits_d;
      chan_q   <= chan_d;
      stereo_q <= stereo_d;
    end
  end

  always_comb begin
    case (reg_sel)
      RegFormat:   prdata = {30'd0, fmt_q};
      RegBits:     prdata = {25'd0, bits_q};
      RegChannels: prdata = {30'd0, chan_q};
      RegStereo:   prdata = {31'd0, stereo_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Frame layout: sample width, byte picks and lane feeds
  // ---------------------------------------------------------------------
  logic [3:0]   nbytes;       // 1..8
  logic [3:0]   left_idx, right_idx;
  logic [127:0] frame;
  logic [7:0]   left_pcm, right_pcm;
  logic         is_double, pcm_offset;
  logic [63:0]  left_word, right_word;

  always_comb begin
    // clamp the byte width to 1..8
    if (bits_q[6:3] == 4'd0) begin
      nbytes = 4'd1;
    end else if (bits_q[6:3] > 4'd8) begin
      nbytes = 4'd8;
    end else begin
      nbytes = bits_q[6:3];
    end
    left_idx   = nbytes - 4'd1;
    right_idx  = {nbytes[2:0], 1'b0} - 4'd1;
    frame      = {frame_high_i, frame_low_i};
    left_pcm   = frame[{left_idx, 3'b000} +: 8];
    right_pcm  = frame[{right_idx, 3'b000} +: 8];
    is_double  = (nbytes == 4'd8);
    pcm_offset = (nbytes != 4'd1);
    // doubles take a whole half of the frame, singles one word of the low half
    left_word  = frame_low_i;
    right_word = is_double ? frame_high_i : {32'd0, frame_low_i[63:32]};
  end

  // ---------------------------------------------------------------------
  // Conversion lanes
  // ---------------------------------------------------------------------
  logic [7:0] left_conv, right_conv;

  afu8_lane u_left_lane (
    .clk_i        (clk_i),
    .fmt_i        (fmt_q),
    .is_double_i  (is_double),
    .pcm_offset_i (pcm_offset),
    .pcm_byte_i   (left_pcm),
    .law_code_i   (frame_low_i[7:0]),
    .word_i       (left_word),
    .sample_o     (left_conv)
  );

  afu8_lane u_right_lane (
    .clk_i        (clk_i),
    .fmt_i        (fmt_q),
    .is_double_i  (is_double),
    .pcm_offset_i (pcm_offset),
    .pcm_byte_i   (right_pcm),
    .law_code_i   (frame_low_i[15:8]),
    .word_i       (right_word),
    .sample_o     (right_conv)
  );

  // ---------------------------------------------------------------------
  // Control pipeline: advance beside the two lane stages
  // ---------------------------------------------------------------------
  ctl_t ctl_in;
  ctl_t ctl1_q, ctl2_q;

  assign busy               = 1'b0;
  assign ctl_in.valid       = start & ~busy;
  assign ctl_in.final_frame = final_frame_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_in;
      ctl2_q <= ctl1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Merge and output register
  // ---------------------------------------------------------------------
  afu8_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl2_q),
    .left_i          (left_conv),
    .right_i         (right_conv),
    .stereo_file_i   (chan_q == 2'd2),
    .stereo_out_i    (stereo_q),
    .done_o          (done_o),
    .left_sample_o   (left_sample_o),
    .right_sample_o  (right_sample_o),
    .right_present_o (right_present_o),
    .final_out_o     (final_out_o)
  );

endmodule

/* rtl/core/afu8_lane.sv */
`timescale 1ns / 1ps

module afu8_lane (
  input  logic               clk_i,
  input  afu8_pkg::fmt_e     fmt_i,
  input  logic               is_double_i,
  input  logic               pcm_offset_i,
  input  logic [7:0]         pcm_byte_i,
  input  logic [7:0]         law_code_i,
  input  logic [63:0]        word_i,
  output logic [7:0]         sample_o
);
  import afu8_pkg::*;

  // Stage one: decode, expand, form the scaled product
  logic [7:0]       byte_d, byte_q;
  logic             shift_en_d, shift_en_q;
  logic             neg_d, neg_q;
  logic [ProdW-1:0] num_d, num_q;
  logic [ShW-1:0]   sh_d, sh_q;

  logic [7:0]  us, as_;
  logic [15:0] ut, at, lin;
  logic [2:0]  aseg;
  logic [7:0]  se;
  logic [10:0] de;
  logic [52:0] dmant;
  logic [7:0]  sat_byte;

  always_comb begin
    // mu-law expand
    us  = ~law_code_i;
    ut  = 16'({us[3:0], 3'b000}) + 16'h0084;
    ut  = ut << us[6:4];
    // A-law expand
    as_  = law_code_i ^ 8'h55;
    aseg = as_[6:4];
    at   = 16'({as_[3:0], 4'b0000});
    if (aseg == 3'd0) begin
      at = at + 16'd8;
    end else begin
      at = at + 16'h0108;
      at = at << (aseg - 3'd1);
    end

    se       = word_i[30:23];
    de       = word_i[62:52];
    dmant    = {1'b1, word_i[51:0]};
    sat_byte = 8'hff;

    byte_d     = Silence;
    shift_en_d = 1'b0;
    neg_d      = 1'b0;
    num_d      = '0;
    sh_d       = '0;
    lin        = '0;

    case (fmt_i)
      FmtPcm: begin
        byte_d = pcm_offset_i ? (pcm_byte_i + Silence) : pcm_byte_i;
      end
      FmtAlaw: begin
        lin    = as_[7] ? at : (16'd0 - at);
        byte_d = lin[15:8] ^ Silence;
      end
      FmtUlaw: begin
        lin    = us[7] ? (16'h0084 - ut) : (ut - 16'h0084);
        byte_d = lin[15:8] ^ Silence;
      end
      FmtFloat: begin
        if (is_double_i) begin
          neg_d    = word_i[63];
          sat_byte = neg_d ? 8'h00 : 8'hff;
          if (de == 11'd2047 && word_i[51:0] != 52'd0) begin
            byte_d = Silence;
          end else if (de >= 11'd1054) begin
            byte_d = sat_byte;
          end else if (de <= 11'd991) begin
            byte_d = Silence;
          end else begin
            shift_en_d = 1'b1;
            num_d      = ({31'd0, dmant} << 31) - {31'd0, dmant};
            sh_d       = 7'(11'd1075 - de);
          end
        end else begin
          neg_d    = word_i[31];
          sat_byte = neg_d ? 8'h00 : 8'hff;
          if (se == 8'd255 && word_i[22:0] != 23'd0) begin
            byte_d = Silence;
          end else if (se >= 8'd127) begin
            byte_d = sat_byte;
          end else if (se <= 8'd87) begin
            byte_d = Silence;
          end else begin
            shift_en_d = 1'b1;
            num_d      = {52'd0, 1'b1, word_i[22:0], 8'd0};
            sh_d       = 7'(8'd127 - se);
          end
        end
      end
      default: byte_d = Silence;
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    shift_en_q <= shift_en_d;
    neg_q      <= neg_d;
    num_q      <= num_d;
    sh_q       <= sh_d;
  end

  // Stage two: align, saturate to int32, take the top byte
  logic [ProdW-1:0] shifted;
  logic [63:0]      mag;
  logic [31:0]      negv;
  logic [7:0]       byte2_d, sample_q;

  always_comb begin
    shifted = num_q >> sh_q;
    mag     = shifted[63:0];
    negv    = 32'd0 - mag[31:0];
    byte2_d = byte_q;
    if (shift_en_q) begin
      if (neg_q) begin
        byte2_d = (mag >= 64'h8000_0000) ? 8'h00 : (negv[31:24] ^ Silence);
      end else begin
        byte2_d = (mag > 64'h7fff_ffff) ? 8'hff : (mag[31:24] ^ Silence);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= byte2_d;
  end

  assign sample_o = sample_q;

endmodule

/* rtl/core/afu8_merge.sv */
`timescale 1ns / 1ps

module afu8_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  afu8_pkg::ctl_t   ctl_i,
  input  logic [7:0]       left_i,
  input  logic [7:0]       right_i,
  input  logic             stereo_file_i,
  input  logic             stereo_out_i,
  output logic             done_o,
  output logic [7:0]       left_sample_o,
  output logic [7:0]       right_sample_o,
  output logic             right_present_o,
  output logic             final_out_o
);
  import afu8_pkg::*;

  logic       done_d, done_q;
  logic [7:0] left_d, left_q, right_d, right_q;
  logic       present_d, present_q, final_d, final_q;

  always_comb begin
    done_d    = ctl_i.valid;
    final_d   = ctl_i.final_frame;
    left_d    = left_i;
    present_d = stereo_out_i;
    // copy left for a mono file, park the unused right at silence
    if (!stereo_out_i) begin
      right_d = Silence;
    end else if (stereo_file_i) begin
      right_d = right_i;
    end else begin
      right_d = left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q    <= left_d;
    right_q   <= right_d;
    present_q <= present_d;
    final_q   <= final_d;
  end

  assign done_o          = done_q;
  assign left_sample_o   = left_q;
  assign right_sample_o  = right_q;
  assign right_present_o = present_q;
  assign final_out_o     = final_q;

endmodule
